// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 3;
    localparam int RESULT_CAP  = 8;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_GET_READ    = 3'd0,
        REQ_GET_WRITE   = 3'd1,
        REQ_PUT_KEEP    = 3'd2,
        REQ_PUT_DISCARD = 3'd3,
        REQ_FLUSH       = 3'd4
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_BUSY       = 3'd2,
        ST_NO_FREE    = 3'd3,
        ST_WRAP       = 3'd4,
        ST_PUT_DONE   = 3'd5,
        ST_FLUSH_WB   = 3'd6,
        ST_FLUSH_NONE = 3'd7
    } status_t;

    localparam logic [1:0] ADDR_WAYS_IN_USE = 2'd0;

    typedef struct packed {
        logic rd;
        logic decide;
        logic wr;
        logic flush_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic flush_more;
        logic has_result;
        logic flush_out;
    } sts_t;

endpackage

// ===== rtl/set_assoc_cache_lru_directory.sv =====
// channel | ports                                           | accept
// in      | s_req_type s_set_index s_tag s_way s_modified   | s_valid && s_ready
// out     | m_status m_way_out m_victim_tag m_writeback m_last | m_valid && m_ready
// cfg     | psel penable pwrite paddr pwdata prdata pready   | psel && penable && pwrite
// Get, putback and empty flush pass through accept, set row read, decide and
// write back, then the item is offered; an unknown request drops after decide.
// A flush with dirty ways gives one writeback item per cycle while m_ready holds.
// Rate is set by the set row read-modify-write and the one result in flight.
// Reset is synchronous; per-set written bits stand in for clearing the set rows.
// The block stalls while a result waits for m_ready.
module set_assoc_cache_lru_directory #(
    parameter int MAX_WAYS   = 8,
    parameter int NUM_SETS   = 64,
    parameter int TAG_BITS   = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_set_index,
    input  logic [31:0] s_tag,
    input  logic [2:0]  s_way,
    input  logic        s_modified,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_way_out,
    output logic [31:0] m_victim_tag,
    output logic        m_writeback,
    output logic        m_last
);
    import sacl_pkg::*;

    logic [3:0] ways_reg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WAYS_IN_USE) ? {28'd0, ways_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg <= 4'd8;
        end else if (psel && penable && pwrite && paddr == ADDR_WAYS_IN_USE) begin
            ways_reg <= pwdata[3:0];
        end
    end

    sacl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    sacl_dp #(
        .MAX_WAYS(MAX_WAYS), .NUM_SETS(NUM_SETS),
        .TAG_BITS(TAG_BITS), .STAMP_BITS(STAMP_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ways_in_use(ways_reg),
        .s_req_type(s_req_type), .s_set_index(s_set_index), .s_tag(s_tag),
        .s_way(s_way), .s_modified(s_modified), .cmd(cmd), .sts(sts),
        .m_status(m_status), .m_way_out(m_way_out), .m_victim_tag(m_victim_tag),
        .m_writeback(m_writeback), .m_last(m_last)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready) else $error("accept while result pending");
    a_wb_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback |-> m_victim_tag == 32'd0) else $error("stray victim tag");
    a_flush_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FLUSH_WB |-> m_writeback) else $error("flush without wb");
endmodule

// ===== rtl/sacl_ram.sv =====
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sacl_ctrl.sv =====
module sacl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  sacl_pkg::sts_t sts,
    output sacl_pkg::cmd_t cmd
);
    import sacl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DECIDE, S_OUT, S_FLUSH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd            = '0;
        cmd.rd         = (state_reg == S_IDLE) && s_valid;
        cmd.decide     = (state_reg == S_DECIDE);
        cmd.wr         = (state_reg == S_DECIDE) && sts.has_result;
        cmd.out_load   = (state_reg == S_DECIDE) && sts.has_result;
        cmd.flush_step = (state_reg == S_FLUSH) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!sts.has_result) begin
                        state_reg <= S_IDLE;
                    end else begin
                        m_valid_reg <= !sts.flush_out;
                        state_reg   <= sts.flush_out ? S_FLUSH : S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= sts.flush_more;
                        if (!sts.flush_more) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/sacl_dp.sv =====
module sacl_dp #(
    parameter int MAX_WAYS   = 8,
    parameter int NUM_SETS   = 64,
    parameter int TAG_BITS   = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [3:0]            ways_in_use,
    input  logic [2:0]            s_req_type,
    input  logic [5:0]            s_set_index,
    input  logic [31:0]           s_tag,
    input  logic [2:0]            s_way,
    input  logic                  s_modified,
    input  sacl_pkg::cmd_t        cmd,
    output sacl_pkg::sts_t        sts,
    output logic [2:0]            m_status,
    output logic [2:0]            m_way_out,
    output logic [31:0]           m_victim_tag,
    output logic                  m_writeback,
    output logic                  m_last
);
    import sacl_pkg::*;

    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW = $clog2(MAX_WAYS + 1);
    localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int ST_LO = TAG_BITS;
    localparam int V_LO  = TAG_BITS + STAMP_BITS;
    localparam int B_LO  = V_LO + 1;
    localparam int D_LO  = V_LO + 2;
    localparam int WAY_BITS = TAG_BITS + STAMP_BITS + 3;
    localparam int ROW_BITS = MAX_WAYS * WAY_BITS;

    logic [2:0]          type_reg;
    logic [SW-1:0]       set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [2:0]          way_reg;
    logic                mod_reg;

    logic [NUM_SETS-1:0] cvalid_reg;
    logic [NUM_SETS-1:0] svalid_reg;
    logic                cv_reg, sv_row_reg;

    logic [ROW_BITS-1:0]   row_rd, row_wd;
    logic [STAMP_BITS-1:0] cnt_rd, cnt_wd;
    logic                  row_we, cnt_we;

    logic [SW-1:0] s_set;
    logic [SW-1:0] rd_set;
    assign s_set  = SW'(s_set_index & 6'(NUM_SETS - 1));
    assign rd_set = cmd.rd ? s_set : set_reg;

    sacl_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_SETS)) u_row (
        .aclk(aclk), .we(row_we), .waddr(set_reg), .wdata(row_wd),
        .raddr(rd_set), .rdata(row_rd)
    );
    sacl_ram #(.WIDTH(STAMP_BITS), .DEPTH(NUM_SETS)) u_cnt (
        .aclk(aclk), .we(cnt_we), .waddr(set_reg), .wdata(cnt_wd),
        .raddr(rd_set), .rdata(cnt_rd)
    );

    logic [CW-1:0] n_ways;
    always_comb begin
        if (ways_in_use == 4'd0) begin
            n_ways = CW'(1);
        end else if (32'(ways_in_use) > MAX_WAYS) begin
            n_ways = CW'(MAX_WAYS);
        end else begin
            n_ways = CW'(ways_in_use);
        end
    end

    logic [TAG_BITS-1:0]   tags   [MAX_WAYS];
    logic [STAMP_BITS-1:0] stamps [MAX_WAYS];
    logic [MAX_WAYS-1:0]   v_row, b_row, d_row;
    logic [STAMP_BITS-1:0] cnt;
    logic [STAMP_BITS-1:0] cnt_inc;
    logic [MAX_WAYS-1:0]   act;
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i]   = row_rd[i*WAY_BITS +: TAG_BITS];
            stamps[i] = sv_row_reg ? row_rd[i*WAY_BITS+ST_LO +: STAMP_BITS] : '0;
            v_row[i]  = sv_row_reg && row_rd[i*WAY_BITS+V_LO];
            b_row[i]  = sv_row_reg && row_rd[i*WAY_BITS+B_LO];
            d_row[i]  = sv_row_reg && row_rd[i*WAY_BITS+D_LO];
            act[i]    = (i < 32'(n_ways));
        end
        cnt     = cv_reg ? cnt_rd : '0;
        cnt_inc = cnt + STAMP_BITS'(1);
    end

    logic [MAX_WAYS-1:0] flush_pend_reg;

    logic                  hit_f, vic_f, busy_hit, wrap, has_res;
    logic [WW-1:0]         hit_w, vic_w;
    logic [STAMP_BITS-1:0] best_s;
    logic [MAX_WAYS-1:0]   fl_set, fl_take;
    logic [4:0]            fl_num;
    logic [STATUS_BITS-1:0] st_n;
    logic [2:0]            wo_n;
    logic [31:0]           vt_n;
    logic                  wb_n, last_n;
    logic [MAX_WAYS-1:0]   v_n, b_n, d_n;
    logic [TAG_BITS-1:0]   tg_n [MAX_WAYS];
    logic [STAMP_BITS-1:0] sp_n [MAX_WAYS];
    logic                  is_get, is_put, put_ok;

    always_comb begin
        is_get = (type_reg == REQ_GET_READ) || (type_reg == REQ_GET_WRITE);
        is_put = (type_reg == REQ_PUT_KEEP) || (type_reg == REQ_PUT_DISCARD);
        hit_f = 1'b0; hit_w = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (act[i] && v_row[i] && tags[i] == tag_reg) begin
                hit_f = 1'b1; hit_w = WW'(i);
            end
        end
        vic_f = 1'b0; vic_w = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (act[i] && !b_row[i] && !v_row[i]) begin
                vic_f = 1'b1; vic_w = WW'(i);
            end
        end
        best_s = '1;
        if (!vic_f) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (act[i] && !b_row[i] && (!vic_f || stamps[i] < best_s)) begin
                    vic_f = 1'b1; vic_w = WW'(i); best_s = stamps[i];
                end
            end
        end
        busy_hit = hit_f && b_row[hit_w];
        wrap = (cnt == {STAMP_BITS{1'b1}});
        put_ok = (32'(way_reg) < 32'(n_ways));
        fl_set = act & ~b_row & v_row & d_row;
        fl_take = '0; fl_num = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (fl_set[i] && fl_num < 5'(RESULT_CAP)) begin
                fl_take[i] = 1'b1;
                fl_num = fl_num + 5'd1;
            end
        end

        st_n = ST_HIT; wo_n = '0; vt_n = '0; wb_n = 1'b0; last_n = 1'b1;
        v_n = v_row; b_n = b_row; d_n = d_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            tg_n[i] = tags[i];
            sp_n[i] = stamps[i];
        end
        cnt_wd = cnt; cnt_we = 1'b0; row_we = 1'b0;
        has_res = 1'b1;
        if (is_get) begin
            if (busy_hit) begin
                st_n = ST_BUSY; wo_n = 3'(hit_w);
            end else if (!hit_f && !vic_f) begin
                st_n = ST_NO_FREE;
            end else if (wrap) begin
                st_n = ST_WRAP;
            end else begin
                cnt_wd = cnt_inc; cnt_we = cmd.wr; row_we = cmd.wr;
                if (hit_f) begin
                    st_n = ST_HIT; wo_n = 3'(hit_w);
                    sp_n[hit_w] = cnt_inc;
                    if (type_reg == REQ_GET_WRITE) b_n[hit_w] = 1'b1;
                end else begin
                    st_n = ST_MISS; wo_n = 3'(vic_w);
                    if (v_row[vic_w] && d_row[vic_w]) begin
                        wb_n = 1'b1; vt_n = 32'(tags[vic_w]);
                    end
                    d_n[vic_w] = 1'b0; v_n[vic_w] = 1'b1;
                    tg_n[vic_w] = tag_reg;
                    sp_n[vic_w] = cnt_inc;
                    if (type_reg == REQ_GET_WRITE) b_n[vic_w] = 1'b1;
                end
            end
        end else if (is_put) begin
            st_n = ST_PUT_DONE; wo_n = way_reg;
            if (put_ok) begin
                row_we = cmd.wr;
                sp_n[WW'(way_reg)] = (type_reg == REQ_PUT_KEEP) ? cnt : '0;
                b_n[WW'(way_reg)] = 1'b0;
                if (mod_reg) d_n[WW'(way_reg)] = 1'b1;
            end
        end else if (type_reg == REQ_FLUSH) begin
            if (fl_set == '0) begin
                st_n = ST_FLUSH_NONE;
            end else begin
                row_we = cmd.wr;
                d_n = d_row & ~fl_take;
            end
        end else begin
            has_res = 1'b0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            row_wd[i*WAY_BITS +: TAG_BITS]         = tg_n[i];
            row_wd[i*WAY_BITS+ST_LO +: STAMP_BITS] = sp_n[i];
            row_wd[i*WAY_BITS+V_LO]                = v_n[i];
            row_wd[i*WAY_BITS+B_LO]                = b_n[i];
            row_wd[i*WAY_BITS+D_LO]                = d_n[i];
        end
    end

    logic                ff;
    logic [WW-1:0]       fw;
    logic [MAX_WAYS-1:0] fp_rest;
    always_comb begin
        ff = 1'b0; fw = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (flush_pend_reg[i]) begin
                ff = 1'b1; fw = WW'(i);
            end
        end
        fp_rest = flush_pend_reg;
        if (ff) fp_rest[fw] = 1'b0;
    end

    assign sts.has_result = has_res;
    assign sts.flush_out  = (type_reg == REQ_FLUSH) && (fl_set != '0);
    assign sts.flush_more = ff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg     <= '0;
            svalid_reg     <= '0;
            flush_pend_reg <= '0;
        end else begin
            if (cmd.rd) begin
                type_reg   <= s_req_type;
                set_reg    <= s_set;
                tag_reg    <= TAG_BITS'(s_tag[TW-1:0]);
                way_reg    <= s_way;
                mod_reg    <= s_modified;
                cv_reg     <= cvalid_reg[s_set];
                sv_row_reg <= svalid_reg[s_set];
            end
            if (cmd.wr) begin
                if (type_reg == REQ_FLUSH) flush_pend_reg <= fl_take;
                if (cnt_we) cvalid_reg[set_reg] <= 1'b1;
                if (row_we) svalid_reg[set_reg] <= 1'b1;
            end
            if (cmd.flush_step && ff) begin
                flush_pend_reg <= fp_rest;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load && !sts.flush_out) begin
            m_status     <= st_n;
            m_way_out    <= wo_n;
            m_victim_tag <= vt_n;
            m_writeback  <= wb_n;
            m_last       <= last_n;
        end else if (cmd.flush_step && ff) begin
            m_status     <= ST_FLUSH_WB;
            m_way_out    <= 3'(fw);
            m_victim_tag <= 32'(tags[fw]);
            m_writeback  <= 1'b1;
            m_last       <= (fp_rest == '0);
        end
    end
endmodule
